// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a property at the same clock edge.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// ===== rtl/core/vtpg_pkg.sv =====
// Types, codes, reset values and helper functions of the velocity test pattern generator.
package vtpg_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ENABLE = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  localparam logic [2:0] REASON_RUNNING   = 3'd0;
  localparam logic [2:0] REASON_STOP      = 3'd1;
  localparam logic [2:0] REASON_INACTIVE  = 3'd2;
  localparam logic [2:0] REASON_COMPLETED = 3'd3;
  localparam logic [2:0] REASON_DISABLED  = 3'd4;

  localparam logic [2:0] PAT_CONSTANT     = 3'd0;
  localparam logic [2:0] PAT_PULSE        = 3'd1;
  localparam logic [2:0] PAT_REVERSE      = 3'd2;
  localparam logic [2:0] PAT_STRAFE_LEFT  = 3'd3;
  localparam logic [2:0] PAT_STRAFE_RIGHT = 3'd4;
  localparam logic [2:0] PAT_ROTATE_LEFT  = 3'd5;
  localparam logic [2:0] PAT_ROTATE_RIGHT = 3'd6;

  localparam logic [2:0] REG_PATTERN_SELECT  = 3'd0;
  localparam logic [2:0] REG_MODE_FLAGS      = 3'd1;
  localparam logic [2:0] REG_TARGET_VELOCITY = 3'd2;
  localparam logic [2:0] REG_VELOCITY_LIMIT  = 3'd3;
  localparam logic [2:0] REG_RUN_DURATION    = 3'd4;
  localparam logic [2:0] REG_PULSE_ON        = 3'd5;
  localparam logic [2:0] REG_PULSE_OFF       = 3'd6;
  localparam logic [2:0] REG_STOP_TIMEOUT    = 3'd7;

  localparam int FLAG_REPEAT        = 0;
  localparam int FLAG_ZERO_INACTIVE = 1;
  localparam int FLAG_STOP_BLOCKS   = 2;
  localparam int FLAG_START_ENABLED = 3;

  localparam logic [2:0]  RST_PATTERN_SELECT  = 3'd0;
  localparam logic [3:0]  RST_MODE_FLAGS      = 4'd6;
  localparam logic [47:0] RST_TARGET_VELOCITY = 48'd80;
  localparam logic [47:0] RST_VELOCITY_LIMIT  = 48'h0190_0096_0096;
  localparam logic [31:0] RST_RUN_DURATION    = 32'd2000;
  localparam logic [31:0] RST_PULSE_ON        = 32'd500;
  localparam logic [31:0] RST_PULSE_OFF       = 32'd500;
  localparam logic [31:0] RST_STOP_TIMEOUT    = 32'd500;

  localparam logic signed [15:0] ROTATE_DEFAULT = 16'sd250;
  localparam logic signed [15:0] VEL_MAX        = 16'sh7FFF;
  localparam logic signed [15:0] VEL_MIN        = 16'sh8000;

  typedef struct packed {
    logic [1:0]  op;
    logic        level;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic               has_command;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_turn;
    logic [2:0]         reason;
    logic               run_active;
    logic               run_completed;
    logic               phase_on;
    logic               stop_in_force;
  } result_t;

  typedef struct packed {
    logic [2:0]  pattern_select;
    logic [3:0]  mode_flags;
    logic [47:0] target_velocity;
    logic [47:0] velocity_limit;
    logic [31:0] run_duration_ms;
    logic [31:0] pulse_on_ms;
    logic [31:0] pulse_off_ms;
    logic [31:0] stop_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] turn;
  } vel_t;

  function automatic logic signed [15:0] sat_abs(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == VEL_MIN) begin
      r = VEL_MAX;
    end else if (v < 16'sd0) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v,
                                                     input logic [15:0] lim);
    logic signed [17:0] vw;
    logic signed [17:0] lw;
    logic signed [17:0] nl;
    logic signed [15:0] r;
    vw = {{2{v[15]}}, v};
    lw = $signed({2'b00, lim});
    nl = -lw;
    if (vw > lw) begin
      r = $signed(lim);
    end else if (vw < nl) begin
      r = nl[15:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/vtpg_cfg.sv =====
// Configuration register file of the velocity test pattern generator.
module vtpg_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [47:0]       cfg_data,
  output vtpg_pkg::cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_select  <= vtpg_pkg::RST_PATTERN_SELECT;
      cfg.mode_flags      <= vtpg_pkg::RST_MODE_FLAGS;
      cfg.target_velocity <= vtpg_pkg::RST_TARGET_VELOCITY;
      cfg.velocity_limit  <= vtpg_pkg::RST_VELOCITY_LIMIT;
      cfg.run_duration_ms <= vtpg_pkg::RST_RUN_DURATION;
      cfg.pulse_on_ms     <= vtpg_pkg::RST_PULSE_ON;
      cfg.pulse_off_ms    <= vtpg_pkg::RST_PULSE_OFF;
      cfg.stop_timeout_ms <= vtpg_pkg::RST_STOP_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vtpg_pkg::REG_PATTERN_SELECT:  cfg.pattern_select  <= cfg_data[2:0];
        vtpg_pkg::REG_MODE_FLAGS:      cfg.mode_flags      <= cfg_data[3:0];
        vtpg_pkg::REG_TARGET_VELOCITY: cfg.target_velocity <= cfg_data;
        vtpg_pkg::REG_VELOCITY_LIMIT:  cfg.velocity_limit  <= cfg_data;
        vtpg_pkg::REG_RUN_DURATION:    cfg.run_duration_ms <= cfg_data[31:0];
        vtpg_pkg::REG_PULSE_ON:        cfg.pulse_on_ms     <= cfg_data[31:0];
        vtpg_pkg::REG_PULSE_OFF:       cfg.pulse_off_ms    <= cfg_data[31:0];
        vtpg_pkg::REG_STOP_TIMEOUT:    cfg.stop_timeout_ms <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/vtpg_shape.sv =====
// Pattern shaping and per-axis clamping of the velocity command.
module vtpg_shape (
  input  logic [2:0]      pattern_select,
  input  logic [47:0]     target_velocity,
  input  logic [47:0]     velocity_limit,
  input  logic            phase_on,
  output vtpg_pkg::vel_t  vel
);

  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] wz;
  logic signed [15:0] strafe_mag;
  logic signed [15:0] rotate_mag;
  vtpg_pkg::vel_t     raw;

  assign vx = $signed(target_velocity[15:0]);
  assign vy = $signed(target_velocity[31:16]);
  assign wz = $signed(target_velocity[47:32]);

  assign strafe_mag = vtpg_pkg::sat_abs((vy > 16'sd0) ? vy : vx);
  assign rotate_mag = vtpg_pkg::sat_abs((wz > 16'sd0) ? wz : vtpg_pkg::ROTATE_DEFAULT);

  always_comb begin
    raw.x    = vx;
    raw.y    = vy;
    raw.turn = wz;
    case (pattern_select)
      vtpg_pkg::PAT_PULSE: begin
        if (!phase_on) begin
          raw.x    = 16'sd0;
          raw.y    = 16'sd0;
          raw.turn = 16'sd0;
        end
      end
      vtpg_pkg::PAT_REVERSE: begin
        raw.x = -vtpg_pkg::sat_abs(vx);
      end
      vtpg_pkg::PAT_STRAFE_LEFT: begin
        raw.x = 16'sd0;
        raw.y = strafe_mag;
      end
      vtpg_pkg::PAT_STRAFE_RIGHT: begin
        raw.x = 16'sd0;
        raw.y = -strafe_mag;
      end
      vtpg_pkg::PAT_ROTATE_LEFT: begin
        raw.x    = 16'sd0;
        raw.y    = 16'sd0;
        raw.turn = rotate_mag;
      end
      vtpg_pkg::PAT_ROTATE_RIGHT: begin
        raw.x    = 16'sd0;
        raw.y    = 16'sd0;
        raw.turn = -rotate_mag;
      end
      default: begin
      end
    endcase
  end

  assign vel.x    = vtpg_pkg::clamp_axis(raw.x, velocity_limit[15:0]);
  assign vel.y    = vtpg_pkg::clamp_axis(raw.y, velocity_limit[31:16]);
  assign vel.turn = vtpg_pkg::clamp_axis(raw.turn, velocity_limit[47:32]);

endmodule

// ===== rtl/core/vtpg_engine.sv =====
// Run state, safety-stop tracking and result decision for one request per cycle while fire is asserted.
module vtpg_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  vtpg_pkg::item_t   item,
  input  vtpg_pkg::cfg_t    cfg,
  output logic              has_result,
  output vtpg_pkg::result_t res
);

  logic        active;
  logic        completed;
  logic        pulse_on;
  logic [31:0] run_start;
  logic [31:0] phase_start;
  logic        stop_level;
  logic        stop_seen;
  logic [31:0] stop_stamp;
  logic        autostart_pending;

  logic        active_next;
  logic        completed_next;
  logic        pulse_on_next;
  logic [31:0] run_start_next;
  logic [31:0] phase_start_next;
  logic        stop_level_next;
  logic        stop_seen_next;
  logic [31:0] stop_stamp_next;
  logic        autostart_pending_next;

  logic        known_op;
  logic        auto_begin;
  logic        active_a;
  logic [31:0] run_elapsed;
  logic [31:0] phase_elapsed;
  logic [31:0] stop_age;
  logic        stop_fresh;
  logic        run_over;
  logic        fresh_run;
  logic        pulse_base;
  logic        shape_phase;
  vtpg_pkg::vel_t vel;

  assign known_op   = (item.op == vtpg_pkg::OP_TICK) || (item.op == vtpg_pkg::OP_ENABLE) ||
                      (item.op == vtpg_pkg::OP_STOP);
  assign auto_begin = autostart_pending && cfg.mode_flags[vtpg_pkg::FLAG_START_ENABLED];
  assign active_a   = active || auto_begin;

  assign stop_age      = item.now_ms - stop_stamp;
  assign stop_fresh    = stop_seen && (stop_age <= cfg.stop_timeout_ms) && stop_level;
  assign run_elapsed   = auto_begin ? 32'd0 : (item.now_ms - run_start);
  assign run_over      = run_elapsed >= cfg.run_duration_ms;
  assign fresh_run     = auto_begin || run_over;
  assign phase_elapsed = fresh_run ? 32'd0 : (item.now_ms - phase_start);
  assign pulse_base    = fresh_run ? 1'b1 : pulse_on;

  always_comb begin
    shape_phase = pulse_base;
    if (cfg.pattern_select == vtpg_pkg::PAT_PULSE) begin
      if (pulse_base && (phase_elapsed >= cfg.pulse_on_ms)) begin
        shape_phase = 1'b0;
      end else if (!pulse_base && (phase_elapsed >= cfg.pulse_off_ms)) begin
        shape_phase = 1'b1;
      end
    end
  end

  vtpg_shape u_shape (
    .pattern_select  (cfg.pattern_select),
    .target_velocity (cfg.target_velocity),
    .velocity_limit  (cfg.velocity_limit),
    .phase_on        (shape_phase),
    .vel             (vel)
  );

  always_comb begin
    active_next            = active;
    completed_next         = completed;
    pulse_on_next          = pulse_on;
    run_start_next         = run_start;
    phase_start_next       = phase_start;
    stop_level_next        = stop_level;
    stop_seen_next         = stop_seen;
    stop_stamp_next        = stop_stamp;
    autostart_pending_next = autostart_pending;
    has_result             = 1'b0;
    res.has_command        = 1'b1;
    res.vel_x              = 16'sd0;
    res.vel_y              = 16'sd0;
    res.vel_turn           = 16'sd0;
    res.reason             = vtpg_pkg::REASON_RUNNING;

    if (known_op) begin
      autostart_pending_next = 1'b0;
      if (auto_begin) begin
        active_next      = 1'b1;
        run_start_next   = item.now_ms;
        phase_start_next = item.now_ms;
        pulse_on_next    = 1'b1;
      end
    end

    case (item.op)
      vtpg_pkg::OP_ENABLE: begin
        active_next = item.level;
        if (item.level && !active_a) begin
          run_start_next   = item.now_ms;
          phase_start_next = item.now_ms;
          pulse_on_next    = 1'b1;
          completed_next   = 1'b0;
        end
        if (!item.level) begin
          completed_next = 1'b0;
          has_result     = 1'b1;
          res.reason     = vtpg_pkg::REASON_DISABLED;
        end
      end
      vtpg_pkg::OP_STOP: begin
        stop_level_next = item.level;
        stop_seen_next  = 1'b1;
        stop_stamp_next = item.now_ms;
      end
      vtpg_pkg::OP_TICK: begin
        has_result = 1'b1;
        if (cfg.mode_flags[vtpg_pkg::FLAG_STOP_BLOCKS] && stop_fresh) begin
          res.reason = vtpg_pkg::REASON_STOP;
        end else if (!active_a) begin
          res.has_command = cfg.mode_flags[vtpg_pkg::FLAG_ZERO_INACTIVE];
          res.reason      = completed ? vtpg_pkg::REASON_COMPLETED : vtpg_pkg::REASON_INACTIVE;
        end else if (run_over && !cfg.mode_flags[vtpg_pkg::FLAG_REPEAT]) begin
          active_next    = 1'b0;
          completed_next = 1'b1;
          res.reason     = vtpg_pkg::REASON_COMPLETED;
        end else begin
          if (run_over) begin
            completed_next = 1'b0;
          end
          if (fresh_run) begin
            run_start_next   = item.now_ms;
            phase_start_next = item.now_ms;
          end
          if (shape_phase != pulse_base) begin
            phase_start_next = item.now_ms;
          end
          pulse_on_next = shape_phase;
          res.vel_x     = vel.x;
          res.vel_y     = vel.y;
          res.vel_turn  = vel.turn;
        end
      end
      default: begin
      end
    endcase

    res.run_active    = active_next;
    res.run_completed = completed_next;
    res.phase_on      = pulse_on_next;
    res.stop_in_force = stop_fresh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active            <= 1'b0;
      completed         <= 1'b0;
      pulse_on          <= 1'b1;
      run_start         <= 32'd0;
      phase_start       <= 32'd0;
      stop_level        <= 1'b0;
      stop_seen         <= 1'b0;
      stop_stamp        <= 32'd0;
      autostart_pending <= 1'b1;
    end else if (fire) begin
      active            <= active_next;
      completed         <= completed_next;
      pulse_on          <= pulse_on_next;
      run_start         <= run_start_next;
      phase_start       <= phase_start_next;
      stop_level        <= stop_level_next;
      stop_seen         <= stop_seen_next;
      stop_stamp        <= stop_stamp_next;
      autostart_pending <= autostart_pending_next;
    end
  end

endmodule

// ===== rtl/core/velocity_test_pattern_generator.sv =====
// Top level of the velocity test pattern generator: input register, engine, result register.
// A request is captured in the input register, passes the combinational engine when it fires, and
// its result is captured in the result register; a stalled result holds the request in place.
// Throughput: one request per cycle while result_stall does not hold back a pending result.
// Reset: synchronous rst returns the valid flags, configuration and run state to reset values.
`include "assert_macros.svh"

module velocity_test_pattern_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  vtpg_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output vtpg_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  vtpg_pkg::cfg_t    cfg;
  vtpg_pkg::item_t   held;
  logic              held_valid;
  logic              advance;
  logic              fire;
  logic              has_result;
  vtpg_pkg::result_t res;

  assign cfg_ready  = 1'b1;
  assign advance    = !(result_valid && result_stall);
  assign item_stall = held_valid && !advance;
  assign fire       = held_valid && advance;

  vtpg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vtpg_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (held),
    .cfg        (cfg),
    .has_result (has_result),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      result <= res;
    end
  end

  `ASSERT_IMPLIES(a_stall_only_when_blocked, item_stall, result_valid && result_stall,
                  "input stalled while the result register is free")
  `ASSERT_ALWAYS(a_no_active_and_completed,
                 !(result_valid && result.run_active && result.run_completed),
                 "result shows a run both active and completed")
  `ASSERT_IMPLIES(a_disabled_is_idle,
                  result_valid && (result.reason == vtpg_pkg::REASON_DISABLED),
                  !result.run_active && result.has_command,
                  "disable result with a run still active")
  `ASSERT_IMPLIES(a_running_has_command,
                  result_valid && (result.reason == vtpg_pkg::REASON_RUNNING),
                  result.has_command && result.run_active,
                  "running result without a command or an active run")

endmodule
